// ===== rtl/mcpl_pkg.sv =====
package mcpl_pkg;

	// Defaults for the top-level parameters
	localparam int WAVE_SAMPLES_DEF     = 50;
	localparam int PWM_PERIOD_COUNT_DEF = 1999;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_DUTY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TUNE_AMP   = 3'd4;

	// Operating modes; codes above MODE_HOLD drive full duty
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_PWM   = 3'd1;
	localparam logic [2:0] MODE_TUNE  = 3'd2;
	localparam logic [2:0] MODE_TRACK = 3'd3;
	localparam logic [2:0] MODE_HOLD  = 3'd4;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] prop_gain;
		logic [11:0] integ_gain;
		logic [7:0]  pwm_duty_percent;
		logic [10:0] tune_amplitude;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  adc_sample;
		logic [15:0] current_request;
	} in_item_t;

	typedef struct packed {
		logic [10:0] duty_high_side_a;
		logic [10:0] duty_high_side_b;
		logic [11:0] reference_used;
		logic [11:0] measured_current;
		logic [26:0] control_effort;
		logic        record_valid;
	} out_item_t;

	// One enable per datapath step
	typedef struct packed {
		logic capture;
		logic conv;
		logic err;
		logic mul;
		logic sum;
		logic divp;
		logic divq;
		logic map1;
		logic map2;
		logic load;
	} dp_cmd_t;

endpackage

// ===== rtl/mcpl_stream_if.sv =====
interface mcpl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/motor_current_pi_loop_core.sv =====
// Channel   Dir  Payload                                              Transfer
// sample    in   adc_sample, current_request                          valid & ready
// result    out  duty_high_side_a/b, reference_used, measured_current,
//                control_effort, record_valid                         valid & ready
// cfg       in   cfg_index, cfg_data                                  cfg_we
//
// One tick runs from one sample transfer to the next through a fixed
// sequence of conversion, error, gain multiply, sum, two reciprocal steps for
// the /100 and two bridge-map steps, then the result register load.
// Reset clears integral and wave index, presets the config, idles the control.
// A stalled result holds the sequencer in its last step; no new sample is
// taken until the result register is free or drains.
module motor_current_pi_loop_core #(
	parameter int WAVE_SAMPLES     = mcpl_pkg::WAVE_SAMPLES_DEF,
	parameter int PWM_PERIOD_COUNT = mcpl_pkg::PWM_PERIOD_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mcpl_stream_if.sink                     sample,
	mcpl_stream_if.source                   result,
	input  logic                            cfg_we,
	input  logic [mcpl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcpl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mcpl_pkg::*;

	cfg_t      cfg;
	dp_cmd_t   cmd;
	out_item_t out_item;

	mcpl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcpl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	mcpl_datapath #(
		.WAVE_SAMPLES     (WAVE_SAMPLES),
		.PWM_PERIOD_COUNT (PWM_PERIOD_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.in_item  (sample.data),
		.out_item (out_item)
	);

	assign result.data = out_item;

	// Checks
	localparam logic [10:0] F_MASKED = 11'(PWM_PERIOD_COUNT);

	logic in_xfer;
	assign in_xfer = sample.valid && sample.ready;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !sample.ready)
		else $error("sample taken while a tick is in progress");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && ($signed(result.data.control_effort) > 27'sd1999))
		|-> (result.data.duty_high_side_a == F_MASKED))
		else $error("positive saturated effort without full duty on A");

	a_neg_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && ($signed(result.data.control_effort) < -27'sd1999))
		|-> (result.data.duty_high_side_b == F_MASKED))
		else $error("negative saturated effort without full duty on B");
endmodule

// ===== rtl/mcpl_cfg_regs.sv =====
module mcpl_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mcpl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcpl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mcpl_pkg::cfg_t                   cfg
);
	import mcpl_pkg::*;

	cfg_t cfg_q;

	// Register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode             <= MODE_IDLE;
			cfg_q.prop_gain        <= 12'd100;
			cfg_q.integ_gain       <= 12'd100;
			cfg_q.pwm_duty_percent <= 8'd0;
			cfg_q.tune_amplitude   <= 11'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:       cfg_q.mode             <= cfg_data[2:0];
				REG_PROP_GAIN:  cfg_q.prop_gain        <= cfg_data;
				REG_INTEG_GAIN: cfg_q.integ_gain       <= cfg_data;
				REG_PWM_DUTY:   cfg_q.pwm_duty_percent <= cfg_data[7:0];
				REG_TUNE_AMP:   cfg_q.tune_amplitude   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== rtl/mcpl_ctrl.sv =====
module mcpl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mcpl_pkg::dp_cmd_t cmd
);
	import mcpl_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_CONV = 10'b00_0000_0010,
		ST_ERR  = 10'b00_0000_0100,
		ST_MUL  = 10'b00_0000_1000,
		ST_SUM  = 10'b00_0001_0000,
		ST_DIVP = 10'b00_0010_0000,
		ST_DIVQ = 10'b00_0100_0000,
		ST_MAP1 = 10'b00_1000_0000,
		ST_MAP2 = 10'b01_0000_0000,
		ST_EMIT = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load;

	// Result register is free or drains this cycle
	assign load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Step sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CONV;
			ST_CONV: state_d = ST_ERR;
			ST_ERR:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIVP;
			ST_DIVP: state_d = ST_DIVQ;
			ST_DIVQ: state_d = ST_MAP1;
			ST_MAP1: state_d = ST_MAP2;
			ST_MAP2: state_d = ST_EMIT;
			ST_EMIT: if (load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath commands
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.conv    = (state_q == ST_CONV);
		cmd.err     = (state_q == ST_ERR);
		cmd.mul     = (state_q == ST_MUL);
		cmd.sum     = (state_q == ST_SUM);
		cmd.divp    = (state_q == ST_DIVP);
		cmd.divq    = (state_q == ST_DIVQ);
		cmd.map1    = (state_q == ST_MAP1);
		cmd.map2    = (state_q == ST_MAP2);
		cmd.load    = load;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
endmodule

// ===== rtl/mcpl_datapath.sv =====
module mcpl_datapath #(
	parameter int WAVE_SAMPLES     = mcpl_pkg::WAVE_SAMPLES_DEF,
	parameter int PWM_PERIOD_COUNT = mcpl_pkg::PWM_PERIOD_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mcpl_pkg::cfg_t      cfg,
	input  mcpl_pkg::dp_cmd_t   cmd,
	input  mcpl_pkg::in_item_t  in_item,
	output mcpl_pkg::out_item_t out_item
);
	import mcpl_pkg::*;

	localparam int WIW = $clog2(WAVE_SAMPLES);
	localparam int FW  = $clog2(PWM_PERIOD_COUNT + 1);
	localparam int NW  = FW + 11;
	localparam int DW  = (FW > 11) ? FW : 11;
	localparam int PW  = NW + 28;

	// Reciprocals: x/100 = (x*R)>>40 for x < 2^33, (x*R)>>30 for x < 2^23;
	// x/2000 = (x*R)>>38 for x < 2^27
	localparam logic [33:0] RECIP_100_K40  = 34'd10995116278;
	localparam logic [27:0] RECIP_100_K30  = 28'd10737419;
	localparam logic [27:0] RECIP_2000_K38 = 28'd137438954;

	localparam logic [FW-1:0] F_CNT = FW'(PWM_PERIOD_COUNT);
	localparam logic [DW-1:0] F_EXT = DW'(PWM_PERIOD_COUNT);

	logic loop_mode, pwm_mode, tune_mode;
	assign pwm_mode  = (cfg.mode == MODE_PWM);
	assign tune_mode = (cfg.mode == MODE_TUNE);
	assign loop_mode = tune_mode || (cfg.mode == MODE_TRACK) || (cfg.mode == MODE_HOLD);

	// Input capture
	logic [9:0]  adc_q;
	logic [15:0] req_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			adc_q <= in_item.adc_sample;
			req_q <= in_item.current_request;
		end
	end

	// Conversion step: sensor to mA, reference select, wave index
	logic [10:0]       adc_off;
	logic [21:0]       conv_prod;
	logic [21:0]       conv_adj;
	logic signed [11:0] req_cl;
	logic [10:0]       amp;
	logic signed [11:0] amp_s;
	logic [WIW-1:0]    wave_rd;
	logic [WIW-1:0]    wave_idx_q;
	logic signed [11:0] ref_d;
	logic signed [11:0] ref_q;
	logic signed [11:0] meas_q;

	assign adc_off   = {1'b0, adc_q} - 11'd512;
	assign conv_prod = {{11{adc_off[10]}}, adc_off} * 22'd1500;
	assign conv_adj  = conv_prod + (conv_prod[21] ? 22'd511 : 22'd0);

	always_comb begin
		if ($signed(req_q) > 16'sd2000) begin
			req_cl = 12'sd2000;
		end else if ($signed(req_q) < -16'sd2000) begin
			req_cl = -12'sd2000;
		end else begin
			req_cl = $signed(req_q[11:0]);
		end
	end

	assign amp     = (cfg.tune_amplitude > 11'd2000) ? 11'd2000 : cfg.tune_amplitude;
	assign amp_s   = $signed({1'b0, amp});
	assign wave_rd = (32'(wave_idx_q) >= WAVE_SAMPLES) ? '0 : wave_idx_q;

	always_comb begin
		case (cfg.mode)
			MODE_TUNE:  ref_d = (32'(wave_rd) < WAVE_SAMPLES / 2) ? -amp_s : amp_s;
			MODE_TRACK: ref_d = req_cl;
			MODE_HOLD:  ref_d = req_cl;
			default:    ref_d = 12'sd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.conv) begin
			meas_q <= $signed(conv_adj[20:9]);
			ref_q  <= ref_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_idx_q <= '0;
		end else if (cmd.conv && tune_mode) begin
			if (32'(wave_rd) + 32'd1 >= WAVE_SAMPLES) begin
				wave_idx_q <= '0;
			end else begin
				wave_idx_q <= wave_rd + 1'b1;
			end
		end
	end

	// Error step: error and saturating integral
	localparam logic signed [22:0] INTEG_MAX = 23'sd1048576;
	localparam logic signed [22:0] INTEG_MIN = -23'sd1048576;
	logic signed [12:0] err_d, err_q;
	logic signed [22:0] acc_raw;
	logic signed [21:0] acc_d, acc_q;
	logic signed [21:0] integ_q;

	assign err_d   = {ref_q[11], ref_q} - {meas_q[11], meas_q};
	assign acc_raw = {integ_q[21], integ_q} + {{10{err_d[12]}}, err_d};

	always_comb begin
		if (acc_raw > INTEG_MAX) begin
			acc_d = INTEG_MAX[21:0];
		end else if (acc_raw < INTEG_MIN) begin
			acc_d = INTEG_MIN[21:0];
		end else begin
			acc_d = acc_raw[21:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err) begin
			err_q <= err_d;
			acc_q <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (cmd.err) begin
			if (cfg.mode == MODE_IDLE) begin
				integ_q <= '0;
			end else if (loop_mode) begin
				integ_q <= acc_d;
			end
		end
	end

	// Gain products
	logic signed [25:0] p1_q;
	logic signed [34:0] p2_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p1_q <= $signed({1'b0, cfg.prop_gain}) * err_q;
			p2_q <= $signed({1'b0, cfg.integ_gain}) * acc_q;
		end
	end

	// Sum, split into sign and magnitude (magnitude < 2^33)
	logic [35:0] n_sum;
	logic [35:0] n_abs;
	logic [32:0] mag_q;
	logic        neg_q;
	assign n_sum = {{10{p1_q[25]}}, p1_q} + {p2_q[34], p2_q};
	assign n_abs = n_sum[35] ? (36'd0 - n_sum) : n_sum;
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			mag_q <= n_abs[32:0];
			neg_q <= n_sum[35];
		end
	end

	// Divide by 100: partial products of the reciprocal
	logic [50:0] ph_q;
	logic [49:0] pl_q;
	always_ff @(posedge clk) begin
		if (cmd.divp) begin
			ph_q <= 51'(mag_q[32:16]) * 51'(RECIP_100_K40);
			pl_q <= 50'(mag_q[15:0]) * 50'(RECIP_100_K40);
		end
	end

	logic [66:0] q_tot;
	logic [25:0] q_mag;
	logic signed [26:0] u_q;
	assign q_tot = {ph_q, 16'd0} + 67'(pl_q);
	assign q_mag = q_tot[65:40];
	always_ff @(posedge clk) begin
		if (cmd.divq) begin
			u_q <= neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		end
	end

	// Bridge map, first step: clamp and scale by the period
	logic [25:0] u_abs;
	logic [10:0] v_mag;
	logic [7:0]  p_abs;
	logic [6:0]  p_mag;
	logic [10:0] sel_mag;
	logic [NW-1:0] n_q;
	logic        sneg_q;
	logic        zero_q;

	assign u_abs   = u_q[26] ? 26'(-u_q) : u_q[25:0];
	assign v_mag   = (u_abs >= 26'd2000) ? 11'd1999 : u_abs[10:0];
	assign p_abs   = cfg.pwm_duty_percent[7] ? (8'd0 - cfg.pwm_duty_percent)
		: cfg.pwm_duty_percent;
	assign p_mag   = (p_abs > 8'd100) ? 7'd100 : p_abs[6:0];
	assign sel_mag = pwm_mode ? {4'd0, p_mag} : v_mag;

	always_ff @(posedge clk) begin
		if (cmd.map1) begin
			n_q    <= NW'(F_CNT) * NW'(sel_mag);
			sneg_q <= pwm_mode ? cfg.pwm_duty_percent[7] : u_q[26];
			zero_q <= (sel_mag == 11'd0);
		end
	end

	// Bridge map, second step: divide by 100 or 2000
	logic [PW-1:0] cnt_prod;
	logic [FW-1:0] cnt_q;
	assign cnt_prod = PW'(n_q) * PW'(pwm_mode ? RECIP_100_K30 : RECIP_2000_K38);
	always_ff @(posedge clk) begin
		if (cmd.map2) begin
			cnt_q <= pwm_mode ? cnt_prod[30 +: FW] : cnt_prod[38 +: FW];
		end
	end

	// Result assembly
	logic [DW-1:0] rem_cnt;
	logic [DW-1:0] duty_a, duty_b;
	out_item_t     res_d, res_q;

	assign rem_cnt = F_EXT - DW'(cnt_q);

	always_comb begin
		case (cfg.mode)
			MODE_IDLE: begin
				duty_a = '0;
				duty_b = '0;
			end
			MODE_PWM, MODE_TUNE, MODE_TRACK, MODE_HOLD: begin
				if (zero_q) begin
					duty_a = '0;
					duty_b = '0;
				end else if (sneg_q) begin
					duty_a = rem_cnt;
					duty_b = F_EXT;
				end else begin
					duty_a = F_EXT;
					duty_b = rem_cnt;
				end
			end
			default: begin
				duty_a = F_EXT;
				duty_b = F_EXT;
			end
		endcase
	end

	always_comb begin
		res_d.duty_high_side_a = duty_a[10:0];
		res_d.duty_high_side_b = duty_b[10:0];
		res_d.reference_used   = ref_q;
		res_d.measured_current = meas_q;
		res_d.control_effort   = loop_mode ? u_q : 27'sd0;
		res_d.record_valid     = tune_mode;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q <= res_d;
		end
	end

	assign out_item = res_q;
endmodule

// ===== verif/motor_current_pi_loop_core_tb.sv =====
module motor_current_pi_loop_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcpl_pkg::*;

	localparam int WAVE      = WAVE_SAMPLES_DEF;
	localparam longint PER   = PWM_PERIOD_COUNT_DEF;
	localparam int INTEG_LIM = 1048576;
	localparam int RAND_ITEMS = 1850;
	localparam int QUIET_TAIL = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		cfg_t      cfg;
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	mcpl_stream_if #(.payload_t(in_item_t))  sample_ch ();
	mcpl_stream_if #(.payload_t(out_item_t)) result_ch ();

	motor_current_pi_loop_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: register copy, integral and wave position
	cfg_t cfg_now;
	int integ_acc;
	int wave_pos;

	out_item_t pending_ticks[$];
	stim_row_t dir_rows[$];
	int mismatch_cnt;
	bit idle_on;
	int stall_left;
	int quiet_cycles;

	// PI update with integral saturation and bridge mapping; returns unclamped effort
	function automatic longint pi_update(input int ref_ma, input int meas_ma,
			output longint a, output longint b);
		longint e;
		longint acc;
		longint u;
		longint kp;
		longint ki;
		longint v;
		kp = cfg_now.prop_gain;
		ki = cfg_now.integ_gain;
		e = ref_ma - meas_ma;
		acc = integ_acc + e;
		if (acc > INTEG_LIM) acc = INTEG_LIM;
		if (acc < -INTEG_LIM) acc = -INTEG_LIM;
		integ_acc = int'(acc);
		u = (kp * e + ki * acc) / 100;
		if (u >= 2000) v = 1999;
		else if (u <= -2000) v = -1999;
		else v = u;
		if (v > 0) begin
			a = PER;
			b = PER - (PER * v) / 2000;
		end else if (v < 0) begin
			a = PER + (PER * v) / 2000;
			b = PER;
		end else begin
			a = 0;
			b = 0;
		end
		return u;
	endfunction

	// One control tick of the expected behavior
	function automatic out_item_t predict_tick(input logic [9:0] adc, input logic [15:0] req);
		out_item_t o;
		int adc_i;
		int meas;
		int rq;
		int ref_ma;
		int amp;
		longint a;
		longint b;
		longint u;
		longint pct;
		longint c;
		logic rec;
		adc_i = adc;
		rq = $signed(req);
		meas = (1500 * (adc_i - 512)) / 512;
		if (rq > 2000) rq = 2000;
		if (rq < -2000) rq = -2000;
		a = 0;
		b = 0;
		u = 0;
		ref_ma = 0;
		rec = 1'b0;
		case (cfg_now.mode)
			MODE_IDLE: begin
				integ_acc = 0;
			end
			MODE_PWM: begin
				pct = $signed(cfg_now.pwm_duty_percent);
				if (pct > 100) pct = 100;
				if (pct < -100) pct = -100;
				c = (pct * PER) / 100;
				if (c > 0) begin
					a = PER;
					b = PER - c;
				end else if (c < 0) begin
					a = PER + c;
					b = PER;
				end
			end
			MODE_TUNE: begin
				amp = (cfg_now.tune_amplitude > 11'd2000) ? 2000 : int'(cfg_now.tune_amplitude);
				if (wave_pos >= WAVE) wave_pos = 0;
				ref_ma = (wave_pos < WAVE / 2) ? -amp : amp;
				u = pi_update(ref_ma, meas, a, b);
				rec = 1'b1;
				wave_pos++;
				if (wave_pos >= WAVE) wave_pos = 0;
			end
			MODE_TRACK, MODE_HOLD: begin
				ref_ma = rq;
				u = pi_update(ref_ma, meas, a, b);
			end
			default: begin
				a = PER;
				b = PER;
			end
		endcase
		o.duty_high_side_a = a[10:0];
		o.duty_high_side_b = b[10:0];
		o.reference_used   = ref_ma[11:0];
		o.measured_current = meas[11:0];
		o.control_effort   = u[26:0];
		o.record_valid     = rec;
		return o;
	endfunction

	task automatic add_row(input logic [2:0] mode, input int kp, input int ki,
			input int pct, input int amp, input int adc, input int req,
			input bit typed, input int a, input int b, input int s);
		stim_row_t r;
		r.cfg.mode             = mode;
		r.cfg.prop_gain        = kp[11:0];
		r.cfg.integ_gain       = ki[11:0];
		r.cfg.pwm_duty_percent = pct[7:0];
		r.cfg.tune_amplitude   = amp[10:0];
		r.item.adc_sample      = adc[9:0];
		r.item.current_request = req[15:0];
		r.typed                = typed;
		r.want.duty_high_side_a = a[10:0];
		r.want.duty_high_side_b = b[10:0];
		r.want.reference_used   = '0;
		r.want.measured_current = s[11:0];
		r.want.control_effort   = '0;
		r.want.record_valid     = 1'b0;
		dir_rows.push_back(r);
	endtask

	// Drop valid, wait for every pending tick to return, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_ticks.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	// Write only the registers that change; block must be drained first
	task automatic apply_cfg(input cfg_t nc);
		if (nc == cfg_now) return;
		wait_drained();
		if (nc.mode != cfg_now.mode) put_reg(REG_MODE, {9'd0, nc.mode});
		if (nc.prop_gain != cfg_now.prop_gain) put_reg(REG_PROP_GAIN, nc.prop_gain);
		if (nc.integ_gain != cfg_now.integ_gain) put_reg(REG_INTEG_GAIN, nc.integ_gain);
		if (nc.pwm_duty_percent != cfg_now.pwm_duty_percent)
			put_reg(REG_PWM_DUTY, {4'd0, nc.pwm_duty_percent});
		if (nc.tune_amplitude != cfg_now.tune_amplitude)
			put_reg(REG_TUNE_AMP, {1'b0, nc.tune_amplitude});
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_now = nc;
	endtask

	// Offer one sample, with an optional gap first; predict on transfer
	task automatic send_tick(input in_item_t it, input bit typed, input out_item_t typed_want);
		out_item_t want;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data  <= it;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		want = predict_tick(it.adc_sample, it.current_request);
		if (typed) want = typed_want;
		pending_ticks.push_back(want);
	endtask

	function automatic logic [11:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 12'd0;
			1: return 12'd4095;
			2: return 12'd100;
			5: return 12'($urandom_range(0, 4095));
			default: return 12'($urandom_range(0, 300));
		endcase
	endfunction

	task automatic cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Result sink: ready with random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(1, 11) - 1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Result checker
	always @(posedge clk) begin
		out_item_t w;
		out_item_t g;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			g = result_ch.data;
			if (pending_ticks.size() == 0) begin
				$display("%0t: result with no tick pending, expected none, actual %p", $time, g);
				mismatch_cnt++;
			end else begin
				w = pending_ticks.pop_front();
				cmp_field("duty_high_side_a", w.duty_high_side_a, g.duty_high_side_a);
				cmp_field("duty_high_side_b", w.duty_high_side_b, g.duty_high_side_b);
				cmp_field("reference_used", $signed(w.reference_used), $signed(g.reference_used));
				cmp_field("measured_current", $signed(w.measured_current),
					$signed(g.measured_current));
				cmp_field("control_effort", $signed(w.control_effort), $signed(g.control_effort));
				cmp_field("record_valid", w.record_valid, g.record_valid);
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t r;
		cfg_t nc;
		in_item_t it;
		out_item_t none;
		int sent;
		int len;
		int mode_pick;
		bit saturate;
		bit neg;
		int k;

		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		none = '0;
		idle_on = 1'b1;
		cfg_now = '{mode: MODE_IDLE, prop_gain: 12'd100, integ_gain: 12'd100,
			pwm_duty_percent: 8'd0, tune_amplitude: 11'd200};
		integ_acc = 0;
		wave_pos = 0;

		// Directed rows: reset values, field extremes, every mode, saturations
		add_row(MODE_IDLE, 100, 100, 0, 200, 512, 0, 1, 0, 0, 0);
		add_row(MODE_IDLE, 100, 100, 0, 200, 0, 32767, 1, 0, 0, -1500);
		add_row(MODE_IDLE, 100, 100, 0, 200, 1023, -32768, 1, 0, 0, 1497);
		add_row(MODE_TUNE, 100, 100, 0, 200, 512, 0, 0, 0, 0, 0);
		add_row(MODE_TUNE, 100, 100, 0, 200, 700, 123, 0, 0, 0, 0);
		add_row(MODE_TUNE, 100, 100, 0, 2047, 0, 0, 0, 0, 0, 0);
		add_row(MODE_TUNE, 100, 100, 0, 0, 1023, 0, 0, 0, 0, 0);
		add_row(MODE_PWM, 100, 100, 100, 0, 512, 0, 1, 1999, 0, 0);
		add_row(MODE_PWM, 100, 100, -100, 0, 512, 0, 1, 0, 1999, 0);
		add_row(MODE_PWM, 100, 100, 127, 0, 512, 0, 1, 1999, 0, 0);
		add_row(MODE_PWM, 100, 100, -128, 0, 512, 0, 1, 0, 1999, 0);
		add_row(MODE_PWM, 100, 100, 0, 0, 512, 0, 1, 0, 0, 0);
		add_row(MODE_PWM, 100, 100, 37, 0, 300, 500, 0, 0, 0, 0);
		add_row(3'd5, 100, 100, 37, 0, 512, 0, 1, 1999, 1999, 0);
		add_row(3'd6, 100, 100, 37, 0, 0, 0, 1, 1999, 1999, -1500);
		add_row(3'd7, 100, 100, 37, 0, 1023, 0, 1, 1999, 1999, 1497);
		add_row(MODE_TRACK, 100, 100, 37, 0, 512, 32767, 0, 0, 0, 0);
		add_row(MODE_TRACK, 100, 100, 37, 0, 1023, -32768, 0, 0, 0, 0);
		add_row(MODE_HOLD, 4095, 4095, 37, 0, 0, 2000, 0, 0, 0, 0);
		add_row(MODE_HOLD, 0, 0, 37, 0, 512, -2000, 0, 0, 0, 0);
		add_row(MODE_TRACK, 1, 0, 37, 0, 515, 0, 0, 0, 0, 0);
		add_row(MODE_IDLE, 1, 0, 37, 0, 512, 0, 1, 0, 0, 0);
		add_row(MODE_TRACK, 4095, 0, 37, 0, 512, 1, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			apply_cfg(r.cfg);
			send_tick(r.item, r.typed, r.want);
		end

		// Random phases: new settings per phase, sender paused until drained between
		sent = 0;
		while (sent < RAND_ITEMS) begin
			idle_on = (sent < RAND_ITEMS - QUIET_TAIL) ? ($urandom_range(0, 3) != 0) : 1'b0;
			saturate = ($urandom_range(0, 9) == 0);
			neg = $urandom_range(0, 1);
			mode_pick = $urandom_range(0, 19);
			nc.prop_gain  = pick_gain();
			nc.integ_gain = pick_gain();
			nc.pwm_duty_percent = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 5))
				0: nc.tune_amplitude = 11'd0;
				1: nc.tune_amplitude = 11'd2047;
				2: nc.tune_amplitude = 11'd2000;
				default: nc.tune_amplitude = 11'($urandom_range(0, 2047));
			endcase
			if (saturate) begin
				// long run with a large error of one sign drives the integral into its limit
				nc.mode = ($urandom_range(0, 1) != 0) ? MODE_TRACK : MODE_HOLD;
				len = $urandom_range(350, 420);
			end else begin
				if (mode_pick < 2) nc.mode = MODE_IDLE;
				else if (mode_pick < 4) nc.mode = MODE_PWM;
				else if (mode_pick < 9) nc.mode = MODE_TUNE;
				else if (mode_pick < 14) nc.mode = MODE_TRACK;
				else if (mode_pick < 18) nc.mode = MODE_HOLD;
				else nc.mode = 3'($urandom_range(5, 7));
				len = (nc.mode == MODE_TUNE) ? $urandom_range(50, 120) : $urandom_range(15, 60);
			end
			// phases stop at the start of the quiet tail and at the item count
			if (sent < RAND_ITEMS - QUIET_TAIL) begin
				if (len > RAND_ITEMS - QUIET_TAIL - sent) len = RAND_ITEMS - QUIET_TAIL - sent;
			end else if (len > RAND_ITEMS - sent) begin
				len = RAND_ITEMS - sent;
			end
			apply_cfg(nc);
			for (k = 0; k < len; k++) begin
				if (saturate) begin
					it.adc_sample = neg ? 10'($urandom_range(1003, 1023)) :
						10'($urandom_range(0, 20));
					it.current_request = neg ? 16'(-$urandom_range(2000, 32768)) :
						16'($urandom_range(2000, 32767));
				end else begin
					it.adc_sample = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 1023)) :
						10'($urandom_range(472, 552));
					it.current_request = ($urandom_range(0, 4) < 2) ?
						16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 4400) - 2200);
				end
				send_tick(it, 1'b0, none);
			end
			sent += len;
		end

		wait_drained();
		if (mismatch_cnt == 0 && pending_ticks.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
